>>> sv/iwsp_pkg.sv
// ----------------------------------------------------------------------------
// iwsp_pkg
// Shared types, constants and codes of the instance weight scatter pool.
// ----------------------------------------------------------------------------
package iwsp_pkg;

   localparam int unsigned PIXELS_DEF   = 4096;
   localparam int unsigned IDX_W        = 12;
   localparam int unsigned SIZE_W       = 16;
   localparam int unsigned WGT_W        = 17;
   localparam int unsigned VAL_W        = 32;
   localparam int unsigned CNT_W        = 16;
   localparam int unsigned MODE_W       = 2;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 17;

   localparam logic [WGT_W-1:0]  ONE_Q16  = 17'd65536;
   localparam logic [VAL_W-1:0]  SUM_MAX  = 32'hFFFF_FFFF;
   localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

   localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_OVWR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WMIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WMAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd2;

   localparam logic FUNC_ACC  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic clr_step;  // clearing pass: write one entry
      logic rd;        // read memory at captured index
      logic div_start; // start reciprocal or average divide
      logic div_step;  // one divider iteration
      logic wr;        // write back entry
      logic out_load;  // load result register
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic is_read;
      logic in_range;
      logic skip_acc;
   } sts_type;

endpackage

>>> sv/iwsp_if.sv
// ----------------------------------------------------------------------------
// iwsp_req_if / iwsp_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface iwsp_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [11:0] pixel_index;
   logic [15:0] group_size;
   modport source (output valid, func, pixel_index, group_size, input ready);
   modport sink   (input valid, func, pixel_index, group_size, output ready);
endinterface

interface iwsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_index_res;
   logic [31:0] pooled_value;
   logic        present;
   modport source (output valid, pixel_index_res, pooled_value, present, input ready);
   modport sink   (input valid, pixel_index_res, pooled_value, present, output ready);
endinterface

>>> sv/iwsp_ctrl.sv
// ----------------------------------------------------------------------------
// iwsp_ctrl
// Sequencer: clearing pass, capture, memory read, divide, write back, respond.
// ----------------------------------------------------------------------------
module iwsp_ctrl
   import iwsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_WR   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       acc;

   // a read result waits for the output register to be free
   assign req_ready = (state_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc) begin
               ctl.load = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (sts.skip_acc) begin
               state_in = ST_IDLE;
            end else if (sts.is_read && !sts.in_range) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  ctl.out_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               ctl.rd   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // read data now valid in rdata_ff, start divide
            ctl.div_start = 1'b1;
            state_in      = ST_WR;
         end
         ST_WR: begin
            if (!sts.div_last) begin
               ctl.div_step = 1'b1;
            end else if (!sts.is_read) begin
               ctl.wr   = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               ctl.wr       = 1'b1;
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/iwsp_datapath.sv
// ----------------------------------------------------------------------------
// iwsp_datapath
// Entry memory, bit-serial divider, clamp, merge and result register.
// ----------------------------------------------------------------------------
module iwsp_datapath
   import iwsp_pkg::*;
#(
   parameter int unsigned PIXELS = PIXELS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   input  logic                  req_func,
   input  logic [IDX_W-1:0]      req_pixel_index,
   input  logic [SIZE_W-1:0]     req_group_size,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [IDX_W-1:0]      rsp_pixel_index_res,
   output logic [VAL_W-1:0]      rsp_pooled_value,
   output logic                  rsp_present
);

   localparam int unsigned AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned ENT_W = 1 + CNT_W + VAL_W;
   localparam int unsigned DIV_W = VAL_W;
   localparam int unsigned ITW   = $clog2(DIV_W + 1);

   // csr
   logic [WGT_W-1:0]  wmin_ff, wmax_ff;
   logic [MODE_W-1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wmin_ff <= '0;
         wmax_ff <= ONE_Q16;
         mode_ff <= MODE_SUM;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WMIN: wmin_ff <= csr_wdata[WGT_W-1:0];
            REG_WMAX: wmax_ff <= csr_wdata[WGT_W-1:0];
            REG_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // captured request
   logic              func_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [SIZE_W-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         func_ff <= req_func;
         idx_ff  <= req_pixel_index;
         size_ff <= req_group_size;
      end
   end

   logic in_range;
   assign in_range = ({{(32-IDX_W){1'b0}}, idx_ff} < 32'(PIXELS));

   // clearing pass counter
   logic [AW:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (ctl.clr_step) clr_ff <= clr_ff + 1'b1;
   end

   // entry memory: {present, count, value}
   logic [ENT_W-1:0] mem [PIXELS];
   logic [ENT_W-1:0] rdata_ff;
   logic [ENT_W-1:0] wdata;
   logic [AW-1:0]    addr;
   assign addr = AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (ctl.clr_step) mem[clr_ff[AW-1:0]] <= '0;
      else if (ctl.wr)  mem[addr] <= wdata;
      if (ctl.rd) rdata_ff <= mem[addr];
   end

   logic             e_pres;
   logic [CNT_W-1:0] e_cnt;
   logic [VAL_W-1:0] e_val;
   assign {e_pres, e_cnt, e_val} = rdata_ff;

   // restoring divider, one quotient bit per cycle
   logic [DIV_W-1:0] dvd_ff, quo_ff, rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [ITW-1:0]   it_ff;
   logic [DIV_W:0]   trial;
   logic [DIV_W-1:0] rem_sh;

   assign rem_sh = {rem_ff[DIV_W-2:0], dvd_ff[DIV_W-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         it_ff <= '0;
      end else if (ctl.div_start) begin
         it_ff <= ITW'(DIV_W);
      end else if (ctl.div_step) begin
         it_ff <= it_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         if (func_ff == FUNC_ACC) begin
            dvd_ff <= DIV_W'(ONE_Q16);
            dvs_ff <= DIV_W'(size_ff);
         end else begin
            dvd_ff <= e_val;
            dvs_ff <= DIV_W'(e_cnt);
         end
      end else if (ctl.div_step) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         if (!trial[DIV_W]) begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   // clamp: weight_min wins when above weight_max
   logic [WGT_W-1:0] w_raw, w_hi, wgt;
   assign w_raw = quo_ff[WGT_W-1:0];
   assign w_hi  = (w_raw > wmax_ff) ? wmax_ff : w_raw;
   assign wgt   = (w_hi < wmin_ff) ? wmin_ff : w_hi;

   logic [VAL_W:0]   sum;
   logic [VAL_W-1:0] sum_sat, new_val;
   logic [CNT_W-1:0] new_cnt;
   assign sum     = {1'b0, e_val} + (VAL_W+1)'(wgt);
   assign sum_sat = sum[VAL_W] ? SUM_MAX : sum[VAL_W-1:0];
   assign new_cnt = (e_cnt == CNT_MAX) ? e_cnt : e_cnt + 1'b1;

   always_comb begin
      unique case (mode_ff)
         MODE_SUM, MODE_AVG: new_val = sum_sat;
         MODE_MAX: new_val = (!e_pres || e_val < VAL_W'(wgt)) ? VAL_W'(wgt) : e_val;
         default:  new_val = VAL_W'(wgt);
      endcase
   end

   assign wdata = (func_ff == FUNC_READ) ? '0 : {1'b1, new_cnt, new_val};

   // result
   logic [VAL_W-1:0] rd_val;
   always_comb begin
      if (!in_range || !e_pres)  rd_val = '0;
      else if (mode_ff == MODE_AVG) rd_val = (e_cnt != '0) ? quo_ff : '0;
      else                       rd_val = e_val;
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_pixel_index_res <= idx_ff;
         rsp_pooled_value    <= rd_val;
         rsp_present         <= in_range && e_pres;
      end
   end

   assign sts.clr_last = (clr_ff == (AW+1)'(PIXELS - 1));
   assign sts.div_last = (it_ff == '0);
   assign sts.is_read  = (func_ff == FUNC_READ);
   assign sts.in_range = in_range;
   assign sts.skip_acc = (func_ff == FUNC_ACC) && (!in_range || size_ff == '0);

endmodule

>>> sv/instance_weight_scatter_pool_core.sv
// ----------------------------------------------------------------------------
// instance_weight_scatter_pool_core
// Per-pixel scatter pooling of reciprocal cluster weights.
// ----------------------------------------------------------------------------
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | func, pixel_index, group_size
// rsp     | out | valid/ready   | pixel_index_res, pooled_value, present
// csr     | in  | write enable  | csr_index, csr_wdata
//
// An item passes capture, memory read, then a 32-step bit-serial divider,
// shared by reciprocal and average; skipped or out-of-range items end there.
// After reset a clearing pass sweeps every memory entry; req_ready
// stays low meanwhile. A read waits while the response register is full.
// ----------------------------------------------------------------------------
module instance_weight_scatter_pool_core
   import iwsp_pkg::*;
#(
   parameter int unsigned PIXELS = PIXELS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   iwsp_req_if.sink              req,
   iwsp_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_type ctl;
   sts_type sts;

   iwsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   iwsp_datapath #(.PIXELS(PIXELS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_func            (req.func),
      .req_pixel_index     (req.pixel_index),
      .req_group_size      (req.group_size),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_pixel_index_res (rsp.pixel_index_res),
      .rsp_pooled_value    (rsp.pooled_value),
      .rsp_present         (rsp.present)
   );

endmodule

>>> sv/iwsp_checker.sv
// ----------------------------------------------------------------------------
// iwsp_checker
// Port-level checks of the scatter pool, bound to the top level.
// ----------------------------------------------------------------------------
module iwsp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_present,
   input logic [31:0] rsp_pooled_value
);

   // a transfer in is followed by a busy cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after transfer");

   // an absent pixel reads as zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_pooled_value == 32'd0)
      else $error("absent pixel with value");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pooled_value))
      else $error("response dropped while stalled");

   // no new response unless req_ready was low in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

endmodule

bind instance_weight_scatter_pool_core iwsp_checker u_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_present      (rsp.present),
   .rsp_pooled_value (rsp.pooled_value)
);

>>> verif/tb_instance_weight_scatter_pool_core.sv
// ----------------------------------------------------------------------------
// tb_instance_weight_scatter_pool_core
// Self-checking bench: drives accumulate and read transfers, keeps a shadow
// pixel table to predict each read response, and checks responses in order.
// ----------------------------------------------------------------------------
module tb_instance_weight_scatter_pool_core;
   import iwsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        func;
      logic [11:0] pixel_index;
      logic [15:0] group_size;
   } pix_op_type;

   typedef struct packed {
      logic [11:0] pixel_index;
      logic [31:0] pooled_value;
      logic        present;
   } pool_rd_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_WMIN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   iwsp_req_if req ();
   iwsp_rsp_if rsp ();

   instance_weight_scatter_pool_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow state
   logic [16:0] shd_wmin = 17'd0;
   logic [16:0] shd_wmax = ONE_Q16;
   logic [1:0]  shd_mode = MODE_SUM;
   logic [31:0] shd_value [PIXELS_DEF];
   logic [15:0] shd_count [PIXELS_DEF];
   logic        shd_pres  [PIXELS_DEF];

   pix_op_type  pending_ops[$];
   pool_rd_type expected_reads[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic void predict_op(pix_op_type op);
      logic [31:0] w;
      logic [32:0] sum;
      pool_rd_type r;
      if (op.func == FUNC_ACC) begin
         if (op.group_size == 0) return;
         w = 32'd65536 / op.group_size;
         if (w > shd_wmax) w = shd_wmax;
         if (w < shd_wmin) w = shd_wmin;
         case (shd_mode)
            MODE_SUM, MODE_AVG: begin
               sum = shd_value[op.pixel_index] + w;
               shd_value[op.pixel_index] = sum[32] ? SUM_MAX : sum[31:0];
            end
            MODE_MAX: begin
               if (!shd_pres[op.pixel_index] || shd_value[op.pixel_index] < w)
                  shd_value[op.pixel_index] = w;
            end
            default: shd_value[op.pixel_index] = w;
         endcase
         if (shd_count[op.pixel_index] != CNT_MAX)
            shd_count[op.pixel_index]++;
         shd_pres[op.pixel_index] = 1'b1;
      end else begin
         r.pixel_index = op.pixel_index;
         r.present = shd_pres[op.pixel_index];
         r.pooled_value = shd_value[op.pixel_index];
         if (shd_mode == MODE_AVG)
            r.pooled_value = (shd_count[op.pixel_index] != 0) ?
               r.pooled_value / shd_count[op.pixel_index] : 32'd0;
         if (!r.present) r.pooled_value = 32'd0;
         shd_value[op.pixel_index] = 32'd0;
         shd_count[op.pixel_index] = 16'd0;
         shd_pres[op.pixel_index] = 1'b0;
         expected_reads.push_back(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.func <= FUNC_ACC;
         req.pixel_index <= '0;
         req.group_size <= '0;
         req_gap <= 0;
      end else begin
         if (req.valid && req.ready)
            predict_op('{req.func, req.pixel_index, req.group_size});
         if (!req.valid || req.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               if (!quiet && $urandom_range(0, 7) == 0) begin
                  req_gap <= $urandom_range(0, 4);
                  req.valid <= 1'b0;
               end else begin
                  pix_op_type op;
                  op = pending_ops.pop_front();
                  req.valid <= 1'b1;
                  req.func <= op.func;
                  req.pixel_index <= op.pixel_index;
                  req.group_size <= op.group_size;
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_reads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: pixel %0d", rsp.pixel_index_res);
            end else begin
               pool_rd_type e;
               e = expected_reads.pop_front();
               if (e.pixel_index !== rsp.pixel_index_res ||
                   e.pooled_value !== rsp.pooled_value || e.present !== rsp.present) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("read mismatch: exp pix %0d val %0d pres %0d, got %0d %0d %0d",
                        e.pixel_index, e.pooled_value, e.present,
                        rsp.pixel_index_res, rsp.pooled_value, rsp.present);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 4);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("instance_weight_scatter_pool_core verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [16:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WMIN: shd_wmin = val;
         REG_WMAX: shd_wmax = val;
         default:  shd_mode = val[1:0];
      endcase
   endtask

   task automatic drain_all();
      while (pending_ops.size() > 0 || req.valid || expected_reads.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic push_op(input logic f, input logic [11:0] p, input logic [15:0] s);
      pix_op_type op;
      op.func = f;
      op.pixel_index = p;
      op.group_size = s;
      pending_ops.push_back(op);
   endtask

   // mostly a small hot set of pixels so reads find pooled entries
   task automatic random_phase(input int n);
      int k;
      logic [11:0] p;
      logic [15:0] s;
      for (k = 0; k < n; k++) begin
         p = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
         case ($urandom_range(0, 3))
            0: s = 16'($urandom_range(0, 8));
            1: s = 16'($urandom);
            2: s = 16'($urandom_range(60000, 65535));
            default: s = 16'($urandom_range(1, 300));
         endcase
         push_op($urandom_range(0, 3) == 0 ? FUNC_READ : FUNC_ACC, p, s);
      end
   endtask

   initial begin
      int i;
      int ph;
      for (i = 0; i < PIXELS_DEF; i++) begin
         shd_value[i] = '0;
         shd_count[i] = '0;
         shd_pres[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero cluster, absent pixel, every mode
      push_op(FUNC_READ, 12'd4095, 16'hFFFF);
      push_op(FUNC_ACC, 12'd0, 16'd0);
      push_op(FUNC_READ, 12'd0, 16'd0);
      push_op(FUNC_ACC, 12'd4095, 16'd1);
      push_op(FUNC_ACC, 12'd4095, 16'd1);
      push_op(FUNC_ACC, 12'd4095, 16'hFFFF);
      push_op(FUNC_READ, 12'd4095, 16'd0);
      push_op(FUNC_ACC, 12'hAAA, 16'h5555);
      push_op(FUNC_ACC, 12'h555, 16'hAAAA);
      push_op(FUNC_READ, 12'hAAA, 16'd0);
      push_op(FUNC_READ, 12'h555, 16'd0);
      drain_all();

      write_reg(REG_MODE, {15'd0, MODE_MAX});
      push_op(FUNC_ACC, 12'd7, 16'd3);
      push_op(FUNC_ACC, 12'd7, 16'd2);
      push_op(FUNC_ACC, 12'd7, 16'd9);
      push_op(FUNC_READ, 12'd7, 16'd0);
      drain_all();
      write_reg(REG_MODE, {15'd0, MODE_AVG});
      push_op(FUNC_ACC, 12'd8, 16'd3);
      push_op(FUNC_ACC, 12'd8, 16'd2);
      push_op(FUNC_ACC, 12'd8, 16'd7);
      push_op(FUNC_READ, 12'd8, 16'd0);
      drain_all();
      // min above max: min wins
      write_reg(REG_WMIN, 17'd40000);
      write_reg(REG_WMAX, 17'd100);
      write_reg(REG_MODE, {15'd0, MODE_OVWR});
      push_op(FUNC_ACC, 12'd9, 16'd1);
      push_op(FUNC_ACC, 12'd9, 16'd500);
      push_op(FUNC_READ, 12'd9, 16'd0);
      drain_all();

      for (ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin write_reg(REG_WMIN, 17'd0); write_reg(REG_WMAX, ONE_Q16); end
            1: begin write_reg(REG_WMIN, ONE_Q16); write_reg(REG_WMAX, ONE_Q16); end
            2: begin write_reg(REG_WMIN, 17'd0); write_reg(REG_WMAX, 17'd0); end
            default: begin
               write_reg(REG_WMIN, 17'($urandom_range(0, 2000)));
               write_reg(REG_WMAX, 17'($urandom_range(0, 65536)));
            end
         endcase
         write_reg(REG_MODE, 17'($urandom_range(0, 3)));
         if (ph == 11) quiet = 1'b1;
         random_phase(100);
         drain_all();
      end

      if (mismatches == 0)
         $display("instance_weight_scatter_pool_core verification clean");
      else
         $display("instance_weight_scatter_pool_core verification failed");
      $finish;
   end
endmodule

>>> files.f
sv/iwsp_pkg.sv
sv/iwsp_if.sv
sv/iwsp_ctrl.sv
sv/iwsp_datapath.sv
sv/instance_weight_scatter_pool_core.sv
sv/iwsp_checker.sv
verif/tb_instance_weight_scatter_pool_core.sv
